// File: rtl/stres_pkg.sv
// Shared types and constants for the sample table resolver.
// No dependencies; used by stres_cfg and sample_table_resolver_top.
`default_nettype none

package stres_pkg;

	localparam int MAP_DEPTH_DEF   = 16;
	localparam int CHUNK_DEPTH_DEF = 1024;

	// request codes
	localparam logic [2:0] MODE_CLEAR  = 3'd0;
	localparam logic [2:0] MODE_MAP    = 3'd1;
	localparam logic [2:0] MODE_CHUNK  = 3'd2;
	localparam logic [2:0] MODE_SAMPLE = 3'd3;
	localparam logic [2:0] MODE_PACKET = 3'd4;

	// register indexes
	localparam logic REG_PACKET_MODE   = 1'b0;
	localparam logic REG_CHANNEL_COUNT = 1'b1;

	localparam logic [31:0] PACKET_BYTES = 32'd34;
	localparam int          FRAME_SHIFT  = 6;    // 64 samples per frame

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] entry_start_chunk;
		logic [31:0] entry_samples;
		logic [31:0] data_word;
	} req_beat_t;

	typedef struct packed {
		logic [31:0] sample_offset;
		logic [31:0] unit_bytes;
	} rsp_beat_t;

	typedef struct packed {
		logic       packet_mode;
		logic [7:0] channel_count;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPEN,
		ST_MAP_LAST,
		ST_SCAN,
		ST_UNITS,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// File: rtl/stres_cfg.sv
// APB-style register file: packet_mode and channel_count.
// Depends on stres_pkg (cfg_t, register indexes).
`default_nettype none

module stres_cfg (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        psel,
	input  wire  logic        penable,
	input  wire  logic        pwrite,
	input  wire  logic [2:0]  paddr,
	input  wire  logic [31:0] pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output stres_pkg::cfg_t   cfg
);

	stres_pkg::cfg_t cfg_q;
	logic            wr_en;
	logic            reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.packet_mode   <= 1'b0;
			cfg_q.channel_count <= 8'd0;
		end else if (wr_en) begin
			case (reg_sel)
				stres_pkg::REG_PACKET_MODE:   cfg_q.packet_mode   <= pwdata[0];
				stres_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			stres_pkg::REG_PACKET_MODE:   prdata = {31'd0, cfg_q.packet_mode};
			stres_pkg::REG_CHANNEL_COUNT: prdata = {24'd0, cfg_q.channel_count};
			default:                      prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/sample_table_resolver_top.sv
// Sample table resolver top level: mapping and chunk memories, request FSM.
// Depends on stres_pkg and stres_cfg.
`default_nettype none

// Channel   Direction  Beat          Handshake
// req       in         req_beat_t    req_valid / req_ready
// rsp       out        rsp_beat_t    rsp_valid / rsp_ready
// apb       in/out     32-bit regs   psel, penable, pwrite, pready (always 1)
//
// Clear and table loads complete when accepted. A request into an open chunk
// goes through accept and emit. Opening a chunk steps, per chunk tried, through
// open, last-entry fetch, a scan of the mapping entries in turn (bounded by
// map_count) and units, set by the single mapping read port; empty chunks
// repeat it. Reset clears control registers, not the tables, which are
// undefined until loaded: there is no clearing pass. A stalled rsp holds the
// block in the emit step; loads still flow while a result waits in the output register.

module sample_table_resolver_top #(
	parameter int MAP_DEPTH   = stres_pkg::MAP_DEPTH_DEF,
	parameter int CHUNK_DEPTH = stres_pkg::CHUNK_DEPTH_DEF
) (
	input  wire  logic           clk,
	input  wire  logic           arst_n,
	input  wire  logic           req_valid,
	output logic                 req_ready,
	input  wire  stres_pkg::req_beat_t req,
	output logic                 rsp_valid,
	input  wire  logic           rsp_ready,
	output stres_pkg::rsp_beat_t rsp,
	input  wire  logic           psel,
	input  wire  logic           penable,
	input  wire  logic           pwrite,
	input  wire  logic [2:0]     paddr,
	input  wire  logic [31:0]    pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int MAP_AW   = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int MAP_CW   = $clog2(MAP_DEPTH + 1);
	localparam int CHUNK_AW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
	localparam int CHUNK_CW = $clog2(CHUNK_DEPTH + 1);

	// ---------------- configuration ----------------
	stres_pkg::cfg_t cfg;
	logic            packets;

	stres_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign packets = cfg.packet_mode & (cfg.channel_count != 8'd0);

	// ---------------- state ----------------
	stres_pkg::state_t state_q, state_d;

	logic [MAP_CW-1:0]   map_count_q;
	logic [CHUNK_CW-1:0] chunk_count_q;
	logic [CHUNK_CW-1:0] chunk_cursor_q;
	logic                chunk_opened_q;
	logic [31:0]         units_left_q;
	logic [31:0]         running_offset_q;
	logic [7:0]          channel_cursor_q;

	logic                packets_q;     // mode of the request in flight
	logic [31:0]         word_q;
	logic [31:0]         spc_q;
	logic [MAP_AW-1:0]   scan_idx_q;

	stres_pkg::rsp_beat_t rsp_q;
	logic                 rsp_valid_q;

	// ---------------- memories ----------------
	logic [31:0] map_fc_mem  [MAP_DEPTH];
	logic [31:0] map_spc_mem [MAP_DEPTH];
	logic [31:0] chunk_mem   [CHUNK_DEPTH];

	logic [31:0] map_fc_rd_q, map_spc_rd_q, chunk_rd_q;

	logic                map_ren, chunk_ren;
	logic [MAP_AW-1:0]   map_raddr;
	logic                map_wen, chunk_wen;

	// ---------------- decode ----------------
	logic req_fire, is_req, req_ok;
	logic [MAP_CW-1:0] map_last_w;
	logic [MAP_AW-1:0] map_last;
	logic [31:0]       fc_minus1;
	logic              scan_le, scan_stop;
	logic [31:0]       units_w;
	logic              cursor_end;
	logic              emit_go;
	logic              emit_fire;
	logic [31:0]       size_w;
	logic [8:0]        ch_next;
	logic              frame_end;
	logic [31:0]       units_dec;

	assign req_fire = req_valid & req_ready;
	assign is_req   = (req.mode == stres_pkg::MODE_SAMPLE) ||
	                  (req.mode == stres_pkg::MODE_PACKET);
	// request kind must match the current mode
	assign req_ok   = ((req.mode == stres_pkg::MODE_SAMPLE) && !packets) ||
	                  ((req.mode == stres_pkg::MODE_PACKET) && packets);

	assign map_wen   = req_fire && (req.mode == stres_pkg::MODE_MAP) &&
	                   (map_count_q < MAP_CW'(MAP_DEPTH));
	assign chunk_wen = req_fire && (req.mode == stres_pkg::MODE_CHUNK) &&
	                   (chunk_count_q < CHUNK_CW'(CHUNK_DEPTH));

	assign map_last_w = map_count_q - 1'b1;
	assign map_last   = map_last_w[MAP_AW-1:0];
	assign cursor_end = (chunk_cursor_q >= chunk_count_q);

	// mapping scan: an entry covers the chunk when its start chunk - 1 <= cursor
	assign fc_minus1 = map_fc_rd_q - 32'd1;
	assign scan_le   = fc_minus1 <= {{(32-CHUNK_CW){1'b0}}, chunk_cursor_q};
	// a later entry that starts beyond the chunk, or the last loaded entry, ends the scan
	assign scan_stop = (!scan_le && (scan_idx_q != '0)) || (scan_idx_q == map_last);

	assign units_w = packets_q ? (spc_q >> stres_pkg::FRAME_SHIFT) : spc_q;

	assign emit_go   = !rsp_valid_q || rsp_ready;
	assign emit_fire = (state_q == stres_pkg::ST_EMIT) && emit_go;
	assign size_w    = packets_q ? stres_pkg::PACKET_BYTES : word_q;
	assign ch_next   = {1'b0, channel_cursor_q} + 9'd1;
	assign frame_end = ch_next >= {1'b0, cfg.channel_count};
	assign units_dec = units_left_q - 32'd1;

	// ---------------- FSM: next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			stres_pkg::ST_IDLE: begin
				if (req_fire && is_req && req_ok) begin
					if (chunk_opened_q)
						state_d = stres_pkg::ST_EMIT;
					else if (map_count_q != '0)
						state_d = stres_pkg::ST_OPEN;
				end
			end
			stres_pkg::ST_OPEN: begin
				if (cursor_end)
					state_d = stres_pkg::ST_IDLE;
				else
					state_d = stres_pkg::ST_MAP_LAST;
			end
			stres_pkg::ST_MAP_LAST: state_d = stres_pkg::ST_SCAN;
			stres_pkg::ST_SCAN: begin
				if (scan_stop)
					state_d = stres_pkg::ST_UNITS;
			end
			stres_pkg::ST_UNITS: begin
				if (units_w == 32'd0)
					state_d = stres_pkg::ST_OPEN;   // empty chunk, try the next
				else
					state_d = stres_pkg::ST_EMIT;
			end
			stres_pkg::ST_EMIT: begin
				if (emit_go)
					state_d = stres_pkg::ST_IDLE;
			end
			default: state_d = stres_pkg::ST_IDLE;
		endcase
	end

	// ---------------- FSM: outputs ----------------
	always_comb begin
		req_ready = 1'b0;
		map_ren   = 1'b0;
		map_raddr = '0;
		chunk_ren = 1'b0;
		case (state_q)
			stres_pkg::ST_IDLE: req_ready = 1'b1;
			stres_pkg::ST_OPEN: begin
				// fetch last entry (default spc) and the chunk start together
				map_ren   = !cursor_end;
				map_raddr = map_last;
				chunk_ren = !cursor_end;
			end
			stres_pkg::ST_MAP_LAST: begin
				map_ren   = 1'b1;
				map_raddr = '0;
			end
			stres_pkg::ST_SCAN: begin
				map_ren   = !scan_stop;
				map_raddr = scan_idx_q + 1'b1;
			end
			default: ;
		endcase
	end

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (map_wen) begin
			map_fc_mem[map_count_q[MAP_AW-1:0]]  <= req.entry_start_chunk;
			map_spc_mem[map_count_q[MAP_AW-1:0]] <= req.entry_samples;
		end
		if (map_ren) begin
			map_fc_rd_q  <= map_fc_mem[map_raddr];
			map_spc_rd_q <= map_spc_mem[map_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (chunk_wen)
			chunk_mem[chunk_count_q[CHUNK_AW-1:0]] <= req.data_word;
		if (chunk_ren)
			chunk_rd_q <= chunk_mem[chunk_cursor_q[CHUNK_AW-1:0]];
	end

	// ---------------- control and datapath ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= stres_pkg::ST_IDLE;
			map_count_q      <= '0;
			chunk_count_q    <= '0;
			chunk_cursor_q   <= '0;
			chunk_opened_q   <= 1'b0;
			units_left_q     <= 32'd0;
			running_offset_q <= 32'd0;
			channel_cursor_q <= 8'd0;
			rsp_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;

			if (rsp_ready && !emit_fire)
				rsp_valid_q <= 1'b0;

			if (req_fire && (req.mode == stres_pkg::MODE_CLEAR)) begin
				map_count_q      <= '0;
				chunk_count_q    <= '0;
				chunk_cursor_q   <= '0;
				chunk_opened_q   <= 1'b0;
				units_left_q     <= 32'd0;
				running_offset_q <= 32'd0;
				channel_cursor_q <= 8'd0;
			end
			if (map_wen)
				map_count_q <= map_count_q + 1'b1;
			if (chunk_wen)
				chunk_count_q <= chunk_count_q + 1'b1;

			case (state_q)
				stres_pkg::ST_UNITS: begin
					if (units_w == 32'd0) begin
						chunk_cursor_q <= chunk_cursor_q + 1'b1;
					end else begin
						units_left_q     <= units_w;
						running_offset_q <= chunk_rd_q;
						channel_cursor_q <= 8'd0;
						chunk_opened_q   <= 1'b1;
					end
				end
				stres_pkg::ST_EMIT: begin
					if (emit_go) begin
						rsp_valid_q      <= 1'b1;
						running_offset_q <= running_offset_q + size_w;
						if (packets_q) begin
							if (frame_end) begin
								channel_cursor_q <= 8'd0;
								units_left_q     <= units_dec;
								if (units_dec == 32'd0) begin
									chunk_opened_q <= 1'b0;
									chunk_cursor_q <= chunk_cursor_q + 1'b1;
								end
							end else begin
								channel_cursor_q <= ch_next[7:0];
							end
						end else begin
							units_left_q <= units_dec;
							if (units_dec == 32'd0) begin
								chunk_opened_q <= 1'b0;
								chunk_cursor_q <= chunk_cursor_q + 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (req_fire) begin
			packets_q <= packets;
			word_q    <= req.data_word;
		end
		case (state_q)
			stres_pkg::ST_MAP_LAST: begin
				spc_q      <= map_spc_rd_q;
				scan_idx_q <= '0;
			end
			stres_pkg::ST_SCAN: begin
				if (scan_le)
					spc_q <= map_spc_rd_q;
				if (!scan_stop)
					scan_idx_q <= scan_idx_q + 1'b1;
			end
			stres_pkg::ST_EMIT: begin
				if (emit_go) begin
					rsp_q.sample_offset <= running_offset_q;
					rsp_q.unit_bytes    <= size_w;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------- assertions ----------------
	a_open_has_units: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_opened_q |-> (units_left_q != 32'd0))
		else $error("open chunk with no units left");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_cursor_q <= chunk_count_q)
		else $error("chunk cursor beyond loaded chunks");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stres_pkg::ST_SCAN) |-> ({1'b0, scan_idx_q} < (MAP_AW+1)'(map_count_q)))
		else $error("mapping scan beyond loaded entries");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != stres_pkg::ST_IDLE) |-> !req_ready)
		else $error("request taken while busy");

	a_emit_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == stres_pkg::ST_EMIT) && emit_go) |=> rsp_valid_q)
		else $error("emit step produced no result");

endmodule

`default_nettype wire
